// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bavd_pkg.sv =====
// Constants and divide-by-constant helpers for the block average decimator.
package bavd_pkg;

   localparam int BLOCK_LEN = 10;

   localparam int CODE_W   = 16;
   localparam int OFFSET_W = 16;
   localparam int FS_W     = 14;
   localparam int SUM_W    = 21;
   localparam int AVG_W    = 17;
   localparam int FOLD_W   = 16;
   localparam int MV_RAW_W = 15;
   localparam int MV_W     = 14;
   localparam int DIGIT_W  = 4;
   localparam int CSR_W    = 16;
   localparam int COUNT_W  = $clog2(BLOCK_LEN);

   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(BLOCK_LEN - 1);

   // Block divide: sum * ceil(2^25 / BLOCK_LEN) >> 25, exact for sums below 2^21.
   localparam int BDIV_SHIFT = 25;
   localparam int BDIV_MUL_W = 26;
   localparam logic [BDIV_MUL_W-1:0] BDIV_MUL =
      BDIV_MUL_W'(((64'd1 << BDIV_SHIFT) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));
   localparam int BDIV_PROD_W = SUM_W + BDIV_MUL_W;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd2950;
   localparam logic [FS_W-1:0]     FS_RESET     = 14'd6300;

   localparam logic [AVG_W-1:0]    AVG_CLAMP    = 17'd65536;
   localparam logic [AVG_W-1:0]    AVG_HALF_MAX = 17'd32767;
   localparam logic [MV_W-1:0]     MV_CLAMP     = 14'd9999;

   localparam logic [0:0] CSR_CODE_OFFSET   = 1'b0;
   localparam logic [0:0] CSR_FULL_SCALE_MV = 1'b1;

   // avg / 1000 for avg <= 65536: * 67109 >> 26
   function automatic logic [6:0] div1000_avg(input logic [AVG_W-1:0] x);
      logic [33:0] p;
      p = 34'(x) * 34'd67109;
      return p[32:26];
   endfunction

   // mv / 100 for mv <= 9999: * 5243 >> 19
   function automatic logic [6:0] div100_mv(input logic [MV_W-1:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'd5243;
      return p[25:19];
   endfunction

   // x / 100 for x < 1000: * 41 >> 12
   function automatic logic [3:0] div100_small(input logic [9:0] x);
      logic [15:0] p;
      p = 16'(x) * 16'd41;
      return p[15:12];
   endfunction

   // x / 10 for x < 1000: * 205 >> 11
   function automatic logic [6:0] div10_small(input logic [9:0] x);
      logic [17:0] p;
      p = 18'(x) * 18'd205;
      return p[17:11];
   endfunction

   // x % 10 for x < 1000
   function automatic logic [DIGIT_W-1:0] rem10_small(input logic [9:0] x);
      logic [9:0] t;
      t = x - (10'(div10_small(x)) * 10'd10);
      return t[DIGIT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/block_average_volt_digits.sv =====
// Block average decimator with binary and decimal average and voltage read-out.
//
// channel   direction  handshake              words
// req_      in         req_valid / req_stall  sample_code
// rsp_      out        rsp_valid / rsp_stall  average_code, digits, millivolts
// csr_      in         csr_wr_en              code_offset (0), full_scale_mv (1)
//
// One sample per cycle while req_stall is low; one result word per BLOCK_LEN samples.
// A result passes, after the sample that closes its block, through a five-stage
// arithmetic pipeline (block divide, fold and scale multiply, digit splitting) and
// the output register; each stage holds while the next is full.
// req_stall rises only on a block-closing sample when the first stage is full.
// Synchronous reset clears the accumulator, count, valids and restores registers.
`include "assert_macros.svh"

module block_average_volt_digits (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bavd_pkg::CODE_W-1:0]   req_sample_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bavd_pkg::AVG_W-1:0]    rsp_average_code,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_avg_digit_4,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_avg_digit_3,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_avg_digit_2,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_avg_digit_1,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_avg_digit_0,
   output logic [bavd_pkg::MV_W-1:0]     rsp_millivolts,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_volt_digit_3,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_volt_digit_2,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_volt_digit_1,
   output logic [bavd_pkg::DIGIT_W-1:0]  rsp_volt_digit_0,
   input  logic                          csr_wr_en,
   input  logic [0:0]                    csr_index,
   input  logic [bavd_pkg::CSR_W-1:0]    csr_wdata
);
   import bavd_pkg::*;

   logic [OFFSET_W-1:0]    code_offset_ff;
   logic [FS_W-1:0]        full_scale_mv_ff;

   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [COUNT_W-1:0]     count_ff;
   logic                   take, last;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic                   rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

   // stage 1: block sum
   logic [SUM_W-1:0]       sum1_ff;
   logic [BDIV_PROD_W-1:0] bdiv_prod;
   // stage 2: raw average
   logic [SUM_W-1:0]       avg2_raw_ff;
   logic [AVG_W-1:0]       avg_in, fold_diff;
   logic [FOLD_W-1:0]      folded;
   logic [29:0]            mv_prod;
   // stage 3: clamped average, raw millivolts
   logic [AVG_W-1:0]       avg3_ff;
   logic [MV_RAW_W-1:0]    mv3_raw_ff;
   logic [MV_W-1:0]        mv_in;
   logic [6:0]             a_hi_in, m_hi_in;
   logic [9:0]             a_lo_in;
   logic [6:0]             m_lo_in;
   logic [AVG_W-1:0]       a_lo_full;
   logic [MV_W-1:0]        m_lo_full;
   // stage 4: split values
   logic [AVG_W-1:0]       avg4_ff;
   logic [MV_W-1:0]        mv4_ff;
   logic [6:0]             a_hi4_ff, m_hi4_ff, m_lo4_ff;
   logic [9:0]             a_lo4_ff;
   logic [3:0]             ad2_in;
   logic [9:0]             a_r_full;
   // stage 5: most digits
   logic [AVG_W-1:0]       avg5_ff;
   logic [MV_W-1:0]        mv5_ff;
   logic [DIGIT_W-1:0]     ad4_5_ff, ad3_5_ff, ad2_5_ff;
   logic [DIGIT_W-1:0]     vd3_5_ff, vd2_5_ff, vd1_5_ff, vd0_5_ff;
   logic [6:0]             a_r5_ff;
   // output register
   logic [AVG_W-1:0]       out_avg_ff;
   logic [MV_W-1:0]        out_mv_ff;
   logic [DIGIT_W-1:0]     out_ad4_ff, out_ad3_ff, out_ad2_ff, out_ad1_ff, out_ad0_ff;
   logic [DIGIT_W-1:0]     out_vd3_ff, out_vd2_ff, out_vd1_ff, out_vd0_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_offset_ff   <= OFFSET_RESET;
         full_scale_mv_ff <= FS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CODE_OFFSET:   code_offset_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_FULL_SCALE_MV: full_scale_mv_ff <= csr_wdata[FS_W-1:0];
            default: ;
         endcase
      end
   end

   // ready chain, output side first
   assign rdy_out = !rsp_valid_ff || !rsp_stall;
   assign rdy5    = !v5_ff || rdy_out;
   assign rdy4    = !v4_ff || rdy5;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;

   // accumulator
   assign last      = (count_ff == LAST_COUNT);
   assign req_stall = last && !rdy1;
   assign take      = req_valid && !req_stall;
   assign sum_in    = sum_ff + SUM_W'(req_sample_code) + SUM_W'(code_offset_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (take) begin
         if (last) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_ff + COUNT_W'(1);
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1)    v1_ff        <= take && last;
         if (rdy2)    v2_ff        <= v1_ff;
         if (rdy3)    v3_ff        <= v2_ff;
         if (rdy4)    v4_ff        <= v3_ff;
         if (rdy5)    v5_ff        <= v4_ff;
         if (rdy_out) rsp_valid_ff <= v5_ff;
      end
   end

   // stage 1 -> 2: divide by block length
   assign bdiv_prod = BDIV_PROD_W'(sum1_ff) * BDIV_PROD_W'(BDIV_MUL);

   // stage 2 -> 3: clamp, fold, scale
   assign avg_in    = (avg2_raw_ff > SUM_W'(AVG_CLAMP)) ? AVG_CLAMP : avg2_raw_ff[AVG_W-1:0];
   assign fold_diff = AVG_CLAMP - avg_in;
   assign folded    = (avg_in > AVG_HALF_MAX) ? fold_diff[FOLD_W-1:0] : avg_in[FOLD_W-1:0];
   assign mv_prod   = 30'(folded) * 30'(full_scale_mv_ff);

   // stage 3 -> 4: clamp millivolts, split into high and low parts
   assign mv_in     = (mv3_raw_ff > MV_RAW_W'(MV_CLAMP)) ? MV_CLAMP : mv3_raw_ff[MV_W-1:0];
   assign a_hi_in   = div1000_avg(avg3_ff);
   assign a_lo_full = avg3_ff - (AVG_W'(a_hi_in) * AVG_W'(1000));
   assign a_lo_in   = a_lo_full[9:0];
   assign m_hi_in   = div100_mv(mv_in);
   assign m_lo_full = mv_in - (MV_W'(m_hi_in) * MV_W'(100));
   assign m_lo_in   = m_lo_full[6:0];

   // stage 4 -> 5: hundreds digit of the low part
   assign ad2_in   = div100_small(a_lo4_ff);
   assign a_r_full = a_lo4_ff - (10'(ad2_in) * 10'd100);

   always_ff @(posedge clock) begin
      if (take && last && rdy1) begin
         sum1_ff <= sum_in;
      end
      if (v1_ff && rdy2) begin
         avg2_raw_ff <= bdiv_prod[BDIV_SHIFT+SUM_W-1:BDIV_SHIFT];
      end
      if (v2_ff && rdy3) begin
         avg3_ff    <= avg_in;
         mv3_raw_ff <= mv_prod[15+MV_RAW_W-1:15];
      end
      if (v3_ff && rdy4) begin
         avg4_ff  <= avg3_ff;
         mv4_ff   <= mv_in;
         a_hi4_ff <= a_hi_in;
         a_lo4_ff <= a_lo_in;
         m_hi4_ff <= m_hi_in;
         m_lo4_ff <= m_lo_in;
      end
      if (v4_ff && rdy5) begin
         avg5_ff  <= avg4_ff;
         mv5_ff   <= mv4_ff;
         ad4_5_ff <= DIGIT_W'(div10_small(10'(a_hi4_ff)));
         ad3_5_ff <= rem10_small(10'(a_hi4_ff));
         ad2_5_ff <= ad2_in;
         a_r5_ff  <= a_r_full[6:0];
         vd3_5_ff <= DIGIT_W'(div10_small(10'(m_hi4_ff)));
         vd2_5_ff <= rem10_small(10'(m_hi4_ff));
         vd1_5_ff <= DIGIT_W'(div10_small(10'(m_lo4_ff)));
         vd0_5_ff <= rem10_small(10'(m_lo4_ff));
      end
      if (v5_ff && rdy_out) begin
         out_avg_ff <= avg5_ff;
         out_mv_ff  <= mv5_ff;
         out_ad4_ff <= ad4_5_ff;
         out_ad3_ff <= ad3_5_ff;
         out_ad2_ff <= ad2_5_ff;
         out_ad1_ff <= DIGIT_W'(div10_small(10'(a_r5_ff)));
         out_ad0_ff <= rem10_small(10'(a_r5_ff));
         out_vd3_ff <= vd3_5_ff;
         out_vd2_ff <= vd2_5_ff;
         out_vd1_ff <= vd1_5_ff;
         out_vd0_ff <= vd0_5_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average_code = out_avg_ff;
   assign rsp_avg_digit_4  = out_ad4_ff;
   assign rsp_avg_digit_3  = out_ad3_ff;
   assign rsp_avg_digit_2  = out_ad2_ff;
   assign rsp_avg_digit_1  = out_ad1_ff;
   assign rsp_avg_digit_0  = out_ad0_ff;
   assign rsp_millivolts   = out_mv_ff;
   assign rsp_volt_digit_3 = out_vd3_ff;
   assign rsp_volt_digit_2 = out_vd2_ff;
   assign rsp_volt_digit_1 = out_vd1_ff;
   assign rsp_volt_digit_0 = out_vd0_ff;

   `ASSERT_NEXT(a_block_clear, take && last, sum_ff == '0 && count_ff == '0, "accumulator not cleared after block")
   `ASSERT_NEXT(a_stage1_hold, v1_ff && !rdy2, v1_ff && $stable(sum1_ff), "block sum lost while stalled")
   `ASSERT_IMPL(a_volt_digits, rsp_valid, rsp_millivolts == (MV_W'(rsp_volt_digit_3) * MV_W'(1000) + MV_W'(rsp_volt_digit_2) * MV_W'(100) + MV_W'(rsp_volt_digit_1) * MV_W'(10) + MV_W'(rsp_volt_digit_0)), "volt digits disagree with millivolts")
   `ASSERT_IMPL(a_avg_digits, rsp_valid, rsp_average_code == (AVG_W'(rsp_avg_digit_4) * AVG_W'(10000) + AVG_W'(rsp_avg_digit_3) * AVG_W'(1000) + AVG_W'(rsp_avg_digit_2) * AVG_W'(100) + AVG_W'(rsp_avg_digit_1) * AVG_W'(10) + AVG_W'(rsp_avg_digit_0)), "average digits disagree with average")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the block average decimator with decimal read-out.
module tb_top;
   import bavd_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE       = 10;
   localparam int SEGMENTS     = 7;
   localparam int SEGMENT_LEN  = 150;

   typedef struct packed {
      logic [AVG_W-1:0]   average_code;
      logic [DIGIT_W-1:0] avg_digit_4;
      logic [DIGIT_W-1:0] avg_digit_3;
      logic [DIGIT_W-1:0] avg_digit_2;
      logic [DIGIT_W-1:0] avg_digit_1;
      logic [DIGIT_W-1:0] avg_digit_0;
      logic [MV_W-1:0]    millivolts;
      logic [DIGIT_W-1:0] volt_digit_3;
      logic [DIGIT_W-1:0] volt_digit_2;
      logic [DIGIT_W-1:0] volt_digit_1;
      logic [DIGIT_W-1:0] volt_digit_0;
   } readout_type;

   class readout_board_type;
      logic [OFFSET_W-1:0] code_offset;
      logic [FS_W-1:0]     full_scale_mv;
      logic [SUM_W-1:0]    sum_acc;
      int unsigned         taken;
      int unsigned         errors;
      readout_type         expected_readouts[$];

      function new();
         code_offset   = OFFSET_RESET;
         full_scale_mv = FS_RESET;
         sum_acc       = '0;
         taken         = 0;
         errors        = 0;
      endfunction

      function void write_reg(input logic [0:0] idx, input logic [CSR_W-1:0] data);
         if (idx == CSR_CODE_OFFSET) begin
            code_offset = data[OFFSET_W-1:0];
         end else begin
            full_scale_mv = data[FS_W-1:0];
         end
      endfunction

      function void note_sample(input logic [CODE_W-1:0] code);
         int unsigned       avg;
         int unsigned       folded;
         int unsigned       mv;
         longint unsigned   scaled;
         readout_type       r;
         sum_acc = sum_acc + SUM_W'(code) + SUM_W'(code_offset);
         taken++;
         if (taken < BLOCK_LEN) return;
         avg = int'(sum_acc) / BLOCK_LEN;
         if (avg > AVG_CLAMP) avg = 32'(AVG_CLAMP);
         folded = (avg > AVG_HALF_MAX) ? 65536 - avg : avg;
         scaled = (64'(folded) * 64'(full_scale_mv)) >> 15;
         mv = (scaled > MV_CLAMP) ? MV_CLAMP : int'(scaled);
         r.average_code = AVG_W'(avg);
         r.avg_digit_4  = DIGIT_W'(avg / 10000);
         r.avg_digit_3  = DIGIT_W'((avg / 1000) % 10);
         r.avg_digit_2  = DIGIT_W'((avg / 100) % 10);
         r.avg_digit_1  = DIGIT_W'((avg / 10) % 10);
         r.avg_digit_0  = DIGIT_W'(avg % 10);
         r.millivolts   = MV_W'(mv);
         r.volt_digit_3 = DIGIT_W'(mv / 1000);
         r.volt_digit_2 = DIGIT_W'((mv / 100) % 10);
         r.volt_digit_1 = DIGIT_W'((mv / 10) % 10);
         r.volt_digit_0 = DIGIT_W'(mv % 10);
         expected_readouts.push_back(r);
         sum_acc = '0;
         taken   = 0;
      endfunction

      function void compare(input string name, input int unsigned want, input int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_readout(input readout_type got);
         readout_type want;
         if (expected_readouts.size() == 0) begin
            $error("result word with none expected: average_code %0d", got.average_code);
            errors++;
            return;
         end
         want = expected_readouts.pop_front();
         compare("average_code", want.average_code, got.average_code);
         compare("avg_digit_4", want.avg_digit_4, got.avg_digit_4);
         compare("avg_digit_3", want.avg_digit_3, got.avg_digit_3);
         compare("avg_digit_2", want.avg_digit_2, got.avg_digit_2);
         compare("avg_digit_1", want.avg_digit_1, got.avg_digit_1);
         compare("avg_digit_0", want.avg_digit_0, got.avg_digit_0);
         compare("millivolts", want.millivolts, got.millivolts);
         compare("volt_digit_3", want.volt_digit_3, got.volt_digit_3);
         compare("volt_digit_2", want.volt_digit_2, got.volt_digit_2);
         compare("volt_digit_1", want.volt_digit_1, got.volt_digit_1);
         compare("volt_digit_0", want.volt_digit_0, got.volt_digit_0);
      endfunction
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [CODE_W-1:0]   req_sample_code  = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [AVG_W-1:0]    rsp_average_code;
   logic [DIGIT_W-1:0]  rsp_avg_digit_4;
   logic [DIGIT_W-1:0]  rsp_avg_digit_3;
   logic [DIGIT_W-1:0]  rsp_avg_digit_2;
   logic [DIGIT_W-1:0]  rsp_avg_digit_1;
   logic [DIGIT_W-1:0]  rsp_avg_digit_0;
   logic [MV_W-1:0]     rsp_millivolts;
   logic [DIGIT_W-1:0]  rsp_volt_digit_3;
   logic [DIGIT_W-1:0]  rsp_volt_digit_2;
   logic [DIGIT_W-1:0]  rsp_volt_digit_1;
   logic [DIGIT_W-1:0]  rsp_volt_digit_0;
   logic                csr_wr_en        = 1'b0;
   logic [0:0]          csr_index        = CSR_CODE_OFFSET;
   logic [CSR_W-1:0]    csr_wdata        = '0;

   int                  send_gap_pct     = 0;
   int                  stall_pct        = 0;
   int unsigned         quiet_cycles     = 0;
   readout_board_type   board            = new();

   block_average_volt_digits dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_code  (req_sample_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_average_code (rsp_average_code),
      .rsp_avg_digit_4  (rsp_avg_digit_4),
      .rsp_avg_digit_3  (rsp_avg_digit_3),
      .rsp_avg_digit_2  (rsp_avg_digit_2),
      .rsp_avg_digit_1  (rsp_avg_digit_1),
      .rsp_avg_digit_0  (rsp_avg_digit_0),
      .rsp_millivolts   (rsp_millivolts),
      .rsp_volt_digit_3 (rsp_volt_digit_3),
      .rsp_volt_digit_2 (rsp_volt_digit_2),
      .rsp_volt_digit_1 (rsp_volt_digit_1),
      .rsp_volt_digit_0 (rsp_volt_digit_0),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= (int'($urandom_range(0, 99)) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_readout(readout_type'{rsp_average_code, rsp_avg_digit_4,
                                              rsp_avg_digit_3, rsp_avg_digit_2,
                                              rsp_avg_digit_1, rsp_avg_digit_0,
                                              rsp_millivolts, rsp_volt_digit_3,
                                              rsp_volt_digit_2, rsp_volt_digit_1,
                                              rsp_volt_digit_0});
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_code(input logic [CODE_W-1:0] code);
      while (int'($urandom_range(0, 99)) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_sample(code);
      @(negedge clock);
   endtask

   task automatic drain_readouts();
      req_valid <= 1'b0;
      while (board.expected_readouts.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic load_config(input logic [CSR_W-1:0] offset, input logic [CSR_W-1:0] scale);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CODE_OFFSET;
      csr_wdata <= offset;
      board.write_reg(CSR_CODE_OFFSET, offset);
      @(negedge clock);
      csr_index <= CSR_FULL_SCALE_MV;
      csr_wdata <= scale;
      board.write_reg(CSR_FULL_SCALE_MV, scale);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CODE_W-1:0] pick_level();
      case ($urandom_range(0, 3))
         0: pick_level = CODE_W'(32768 - int'(board.code_offset));
         1: pick_level = CODE_W'(65536 - int'(board.code_offset));
         2: pick_level = CODE_W'($urandom_range(0, 4000));
         default: pick_level = CODE_W'($urandom);
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] jitter(input logic [CODE_W-1:0] level);
      jitter = CODE_W'(int'(level) + int'($urandom_range(0, 8)) - 4);
   endfunction

   initial begin
      logic [CODE_W-1:0] level;
      logic [CSR_W-1:0]  offset;
      logic [CSR_W-1:0]  scale;
      bit                steady;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 7;
      stall_pct    = 51;
      repeat (BLOCK_LEN) send_code(16'hFFFF);
      for (int i = 0; i < BLOCK_LEN; i++) send_code((i % 2) ? 16'hFFFF : 16'h0000);
      drain_readouts();
      load_config(16'h0000, 16'hFFFF);
      repeat (BLOCK_LEN) send_code(16'h8000);

      level  = '0;
      steady = 1'b0;
      for (int s = 0; s < SEGMENTS; s++) begin
         drain_readouts();
         case (s)
            0: begin offset = 16'd0;     scale = 16'd9999;  end
            1: begin offset = 16'hFFFF;  scale = 16'hFFFF;  end
            2: begin offset = 16'd0;     scale = 16'd0;     end
            3: begin offset = OFFSET_RESET; scale = CSR_W'(FS_RESET); end
            default: begin
               offset = $urandom_range(0, 1) ? CSR_W'($urandom_range(0, 4000)) : CSR_W'($urandom);
               scale  = $urandom_range(0, 1) ? CSR_W'($urandom_range(0, 9999)) : CSR_W'($urandom);
            end
         endcase
         load_config(offset, scale);
         if (s < 2) begin
            send_gap_pct = 7;
            stall_pct    = 51;
         end else if (s < 4) begin
            send_gap_pct = 51;
            stall_pct    = 7;
         end else begin
            send_gap_pct = 0;
            stall_pct    = 0;
         end
         for (int i = 0; i < SEGMENT_LEN; i++) begin
            if (i % BLOCK_LEN == 0) begin
               level  = pick_level();
               steady = $urandom_range(0, 1);
            end
            if (s == 1 && i == SEGMENT_LEN / 2) drain_readouts();
            if (steady) begin
               send_code(jitter(level));
            end else begin
               case ($urandom_range(0, 7))
                  0: send_code(16'h0000);
                  1: send_code(16'hFFFF);
                  2, 3, 4, 5: send_code(jitter(level));
                  default: send_code(CODE_W'($urandom));
               endcase
            end
         end
      end

      drain_readouts();
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
